// ----- design/hcr_pkg.sv -----
// hcr_pkg: shared types and constants of the harris corner response block
// no dependencies

package hcr_pkg;

	localparam int REG_W = 1;
	localparam logic [REG_W-1:0] REG_IMAGE_WIDTH      = 1'd0;
	localparam logic [REG_W-1:0] REG_CORNER_THRESHOLD = 1'd1;

	localparam int SCALE_SHIFT = 11;
	localparam int SUM_DIVISOR = 25;
	localparam int MIN_WIDTH   = 16;

	// floor(x / 25) = (x * DIV_RECIP) >> DIV_SHIFT for any 32-bit x
	localparam logic [31:0] DIV_RECIP = 32'h51EB851F;
	localparam int          DIV_SHIFT = 35;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_GRAD,
		ST_DRAIN,
		ST_SCALE,
		ST_MULT,
		ST_DIV,
		ST_EMIT
	} hcr_state_t;

endpackage

// ----- design/hcr_ram.sv -----
// hcr_ram: generic single-clock ram, one write port and one registered read port
// no dependencies

module hcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/harris_corner_response.sv -----
// harris_corner_response: top level of the harris corner response block
// depends on hcr_pkg and hcr_ram
//
// Takes one 8-bit pixel per request in raster order and gives the Harris response of the
// window center once BLOCK+2 columns and rows of the frame are in. The previous BLOCK+1
// lines share one ram word per column, so a pixel takes one read and one read-modify-write.
// The gradient sums of a pixel that gives a response visit one block position per cycle
// through a single set of three multipliers, and the division of (a+b)^2 by 25 is one
// 32x32 reciprocal multiplication. A finished response waits in the output register
// while the next pixel is taken; a second response stalls until the first one is taken.

module harris_corner_response import hcr_pkg::*; #(
	parameter int BLOCK     = 7,
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // pixel
	input  logic [0:0]  s_tuser,    // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // center_x, center_y, response, zero fill
	output logic [0:0]  m_tuser,    // is_corner
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [REG_W-1:0] cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int LINES = BLOCK + 1;
	localparam int WIN   = BLOCK + 2;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int LW    = $clog2(LINES);
	localparam int KW    = $clog2(BLOCK);
	localparam int GW    = 11;
	localparam int ACC_W = 2 * GW + $clog2(BLOCK * BLOCK);
	localparam int A_W   = ACC_W - SCALE_SHIFT;
	localparam int DW    = 2 * A_W + 2;
	localparam int RW    = 2 * A_W + 3;
	localparam logic signed [63:0] MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] MIN64 = -64'sd2147483648;
	localparam logic signed [RW-1:0] R_MAX = RW'(MAX64);
	localparam logic signed [RW-1:0] R_MIN = RW'(MIN64);

	hcr_state_t state_q, state_d;

	logic [CW-1:0]  column_count_q, col_q;
	logic [15:0]    row_count_q, row_q;
	logic [LW-1:0]  line_slot_q, slot_q;
	logic [7:0]     pixel_q;
	logic [10:0]    image_width_q;
	logic signed [31:0] threshold_q;
	logic [CW:0]    eff_w;
	logic           hit;

	logic [7:0] win_q    [WIN][WIN];
	logic [7:0] win_load [WIN][WIN];
	logic [7:0] win_rot  [WIN][WIN];
	logic [LW:0] ls;

	logic [KW-1:0] qi_q, ri_q;
	logic          last_q, last_r;

	logic signed [GW-1:0] gx, gy, gx_s1, gy_s1;
	logic                 v_s1;
	logic signed [2*GW-1:0] pxx, pyy, pxy;
	logic signed [ACC_W-1:0] acc_a_q, acc_b_q, acc_c_q, acc_c_adj;
	logic signed [A_W-1:0] a_q, b_q, c_q;
	logic signed [A_W:0]   s_sum;
	logic signed [DW-1:0]  ss;
	logic signed [2*A_W-1:0] ab_q, cc_q;
	logic [DW-1:0]  dq_q;
	logic [63:0]    dprod;
	logic signed [RW-1:0] res;
	logic signed [31:0]   res_sat;

	logic [9:0]  cen_x_q, out_x_q;
	logic [15:0] cen_y_q, out_y_q;
	logic signed [31:0] out_r_q;
	logic        out_c_q, out_valid_q, out_load;

	logic                 ram_rd_en, ram_wr_en;
	logic [CW-1:0]        ram_rd_addr;
	logic [8*LINES-1:0]   ram_rd_data, ram_wr_data;

	function automatic logic signed [GW-1:0] ext(input logic [7:0] p);
		ext = $signed({3'b000, p});
	endfunction

	hcr_ram #(
		.WIDTH(8 * LINES),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(col_q),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// effective line length
	always_comb begin
		if (image_width_q > 11'(MAX_WIDTH > 2047 ? 2047 : MAX_WIDTH) && MAX_WIDTH <= 2047) begin
			eff_w = (CW+1)'(MAX_WIDTH);
		end else if (image_width_q < 11'(MIN_WIDTH)) begin
			eff_w = (CW+1)'(MIN_WIDTH);
		end else begin
			eff_w = (CW+1)'(image_width_q);
		end
	end

	assign hit    = (32'(col_q) >= BLOCK + 1) && (32'(row_q) >= BLOCK + 1);
	assign last_q = (qi_q == KW'(BLOCK - 1));
	assign last_r = (ri_q == KW'(BLOCK - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_LOAD;
			ST_LOAD:  state_d = hit ? ST_GRAD : ST_IDLE;
			ST_GRAD:  if (last_q && last_r) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_MULT;
			ST_MULT:  state_d = ST_DIV;
			ST_DIV:   state_d = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready    = 1'b0;
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		out_load    = 1'b0;
		ram_rd_addr = s_tuser[0] ? '0 : column_count_q;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_rd_en = s_tvalid;
			end
			ST_LOAD: ram_wr_en = 1'b1;
			ST_EMIT: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// window shift on a new column, and rotation during the gradient sweep
	always_comb begin
		ls = '0;
		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN - 1; c++) begin
				win_load[r][c] = win_q[r][c+1];
			end
		end
		for (int r = 0; r < LINES; r++) begin
			ls = (LW+1)'(slot_q) + (LW+1)'(r);
			if (ls >= (LW+1)'(LINES)) begin
				ls = ls - (LW+1)'(LINES);
			end
			win_load[r][WIN-1] = ram_rd_data[8*ls[LW-1:0] +: 8];
		end
		win_load[WIN-1][WIN-1] = pixel_q;
		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN; c++) begin
				if (!last_q) begin
					win_rot[r][c] = win_q[r][(c+1)%WIN];
				end else if (last_r) begin
					win_rot[r][c] = win_q[(r+3)%WIN][(c+3)%WIN];
				end else begin
					win_rot[r][c] = win_q[(r+1)%WIN][(c+3)%WIN];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			ram_wr_data[8*k +: 8] = (slot_q == LW'(k)) ? pixel_q : ram_rd_data[8*k +: 8];
		end
	end

	// sobel at the top-left 3x3 of the rotating window
	assign gx = ((ext(win_q[1][2]) - ext(win_q[1][0])) <<< 1)
		+ (ext(win_q[0][2]) - ext(win_q[0][0]))
		+ (ext(win_q[2][2]) - ext(win_q[2][0]));
	assign gy = ((ext(win_q[2][1]) - ext(win_q[0][1])) <<< 1)
		+ (ext(win_q[2][0]) - ext(win_q[0][0]))
		+ (ext(win_q[2][2]) - ext(win_q[0][2]));

	assign pxx = gx_s1 * gx_s1;
	assign pyy = gy_s1 * gy_s1;
	assign pxy = gx_s1 * gy_s1;

	assign acc_c_adj = acc_c_q + (acc_c_q < 0 ? ACC_W'((1 << SCALE_SHIFT) - 1) : '0);
	assign s_sum     = (A_W+1)'(a_q) + (A_W+1)'(b_q);
	assign ss        = s_sum * s_sum;

	// (a+b)^2 stays below 2^32 since a+b is at most 2*49*1020^2/2048
	assign dprod     = dq_q[31:0] * DIV_RECIP;

	always_comb begin
		res = RW'(ab_q) - RW'(cc_q) - $signed({1'b0, dq_q});
		if (res > R_MAX) begin
			res_sat = 32'(MAX64);
		end else if (res < R_MIN) begin
			res_sat = 32'(MIN64);
		end else begin
			res_sat = 32'(res);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			column_count_q <= '0;
			row_count_q    <= '0;
			line_slot_q    <= '0;
			out_valid_q    <= 1'b0;
			image_width_q  <= 11'd640;
			threshold_q    <= 32'sd1000;
			v_s1           <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_GRAD);
			if (cfg_valid) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH:      image_width_q <= cfg_data[10:0];
					REG_CORNER_THRESHOLD: threshold_q <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (state_q == ST_LOAD) begin
				if ((CW+1)'(col_q) + (CW+1)'(1) >= eff_w) begin
					column_count_q <= '0;
					row_count_q    <= row_q + 16'd1;
					line_slot_q    <= (slot_q == LW'(LINES - 1)) ? '0 : slot_q + LW'(1);
				end else begin
					column_count_q <= col_q + CW'(1);
					row_count_q    <= row_q;
					line_slot_q    <= slot_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					pixel_q <= s_tdata;
					col_q   <= s_tuser[0] ? '0 : column_count_q;
					row_q   <= s_tuser[0] ? '0 : row_count_q;
					slot_q  <= s_tuser[0] ? '0 : line_slot_q;
				end
			end
			ST_LOAD: begin
				win_q   <= win_load;
				qi_q    <= '0;
				ri_q    <= '0;
				acc_a_q <= '0;
				acc_b_q <= '0;
				acc_c_q <= '0;
				cen_x_q <= 10'(32'(col_q) - BLOCK + BLOCK / 2);
				cen_y_q <= 16'(32'(row_q) - BLOCK + BLOCK / 2);
			end
			ST_GRAD: begin
				win_q <= win_rot;
				gx_s1 <= gx;
				gy_s1 <= gy;
				if (last_q) begin
					qi_q <= '0;
					ri_q <= ri_q + KW'(1);
				end else begin
					qi_q <= qi_q + KW'(1);
				end
			end
			ST_SCALE: begin
				a_q <= A_W'(acc_a_q >>> SCALE_SHIFT);
				b_q <= A_W'(acc_b_q >>> SCALE_SHIFT);
				c_q <= A_W'(acc_c_adj >>> SCALE_SHIFT);
			end
			ST_MULT: begin
				ab_q <= a_q * b_q;
				cc_q <= c_q * c_q;
				dq_q <= ss;
			end
			ST_DIV: begin
				dq_q <= DW'(dprod >> DIV_SHIFT);
			end
			default: ;
		endcase
		if (v_s1) begin
			acc_a_q <= acc_a_q + ACC_W'(pxx);
			acc_b_q <= acc_b_q + ACC_W'(pyy);
			acc_c_q <= acc_c_q + ACC_W'(pxy);
		end
		if (out_load) begin
			out_x_q <= cen_x_q;
			out_y_q <= cen_y_q;
			out_r_q <= res_sat;
			out_c_q <= (res_sat > threshold_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'b000000, out_r_q, out_y_q, out_x_q};
	assign m_tuser   = out_c_q;

endmodule
